[src/cfs_pkg.sv]
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants of the circumsphere unit
// Item structs, datapath widths, pipeline latencies and the minor pair table.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // Input item: four points, signed Q16.16
  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic signed [31:0] p3_z;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
  } cfs_in_t;

  // Result item: center, radius and flags
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
    logic               coplanar;
    logic               overflow;
  } cfs_out_t;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;             // point minus d
  localparam int PROD_W  = 66;             // product of two differences
  localparam int MD_W    = 65;             // difference times d coordinate
  localparam int COF_W   = 67;             // 2x2 cofactor
  localparam int G_W     = 68;             // squared norm plus 2*m*d
  localparam int NUM_W   = COF_W + G_W;    // Cramer numerator
  localparam int DET_W   = COF_W + DIFF_W; // determinant
  localparam int QUO_W   = 32;             // quotient bits resolved
  localparam int RAD_W   = 31;
  localparam int SQ_W    = 62;             // radicand after saturation check
  localparam int SQRT_STEPS = 31;

  localparam int COPLANAR_LIMIT = 281;
  localparam logic [SQ_W-1:0] SLIM = 62'h3FFF_FFFF_8000_0000;
  localparam logic signed [COORD_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_NEG = 32'sh8000_0000;

  localparam int MUL_LAT = 3;
  localparam int DIV_LAT = QUO_W + 4;
  localparam int RAD_LAT = SQRT_STEPS + 4;

  // Product pairs of matrix entries; cofactor c = pair 2c minus pair 2c+1
  localparam int PAIR_A [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
  localparam int PAIR_B [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

endpackage

[src/cfs_delay.sv]
// ----------------------------------------------------------------------------
// cfs_delay: side-band delay line
// Shifts a word through DEPTH registers that advance with the pipeline.
// ----------------------------------------------------------------------------
module cfs_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [DEPTH];

  // Advance the line
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[DEPTH-1];
endmodule

[src/cfs_mul.sv]
// ----------------------------------------------------------------------------
// cfs_mul: pipelined wide signed multiplier
// Splits both operands in 32-bit chunks, registers the partial products,
// then sums rows and columns in two more stages.
// ----------------------------------------------------------------------------
module cfs_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);
  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WS = 32 * (NA + NB) + 2;

  logic signed [32*NA-1:0] ax;
  logic signed [32*NB-1:0] bx;
  logic signed [32:0]      ca [NA];
  logic signed [32:0]      cb [NB];
  logic signed [65:0]      pp [NA][NB];
  logic signed [WS-1:0]    row_next [NB];
  logic signed [WS-1:0]    row [NB];
  logic signed [WS-1:0]    sum_next;

  assign ax = (32*NA)'(a);
  assign bx = (32*NB)'(b);

  // Cut operands: lower chunks unsigned, top chunk carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_ca
    if (i == NA - 1) begin : g_top
      assign ca[i] = {ax[32*i+31], ax[32*i +: 32]};
    end else begin : g_low
      assign ca[i] = {1'b0, ax[32*i +: 32]};
    end
  end
  for (genvar j = 0; j < NB; j++) begin : g_cb
    if (j == NB - 1) begin : g_top
      assign cb[j] = {bx[32*j+31], bx[32*j +: 32]};
    end else begin : g_low
      assign cb[j] = {1'b0, bx[32*j +: 32]};
    end
  end

  // Sum each row of partials, then the rows
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_next[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_next[j] = row_next[j] + (WS'(pp[i][j]) <<< (32 * i));
      end
    end
    sum_next = '0;
    for (int j = 0; j < NB; j++) sum_next = sum_next + (row[j] <<< (32 * j));
  end

  // Advance the three stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++)
        for (int j = 0; j < NB; j++) pp[i][j] <= ca[i] * cb[j];
      for (int j = 0; j < NB; j++) row[j] <= row_next[j];
      p <= sum_next[WA+WB-1:0];
    end
  end
endmodule

[src/cfs_div.sv]
// ----------------------------------------------------------------------------
// cfs_div: pipelined rounding divider for one center coordinate
// Returns round(num / (2*det)) with ties away from zero, one quotient bit per
// stage, saturated to signed 32 bits with an overflow flag.
// ----------------------------------------------------------------------------
module cfs_div #(
  parameter int WN = 135,
  parameter int WD = 100
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WN-1:0]  num,
  input  logic signed [WD-1:0]  det,
  output logic signed [31:0]    cen,
  output logic                  ovf
);
  import cfs_pkg::*;

  localparam int QB = QUO_W;
  localparam int WR = (WN + 1 > WD + 1 + QB) ? WN + 1 : WD + 1 + QB;

  logic [WN-1:0] an;
  logic [WD-1:0] ad;
  logic          neg_a;
  logic [WR-1:0] rem [QB+2];
  logic [WR-1:0] dv  [QB+2];
  logic [QB-1:0] q   [QB+2];
  logic          neg [QB+2];
  logic          big [QB+2];
  logic          sat;

  // Take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      an    <= num[WN-1] ? WN'(-num) : WN'(num);
      ad    <= det[WD-1] ? WD'(-det) : WD'(det);
      neg_a <= num[WN-1] ^ det[WD-1];
    end
  end

  // Form dividend |num|+|det| over divisor 2|det|
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= WR'(an) + WR'(ad);
      dv[0]  <= WR'(ad) << 1;
      q[0]   <= '0;
      neg[0] <= neg_a;
      big[0] <= 1'b0;
    end
  end

  // Resolve one quotient bit per stage; the first stage flags a quotient
  // that does not fit in QB bits
  for (genvar s = 0; s <= QB; s++) begin : g_step
    localparam int J = QB - s;
    logic [WR-1:0] shd;
    logic          take;
    assign shd  = dv[s] << J;
    assign take = rem[s] >= shd;
    if (s == 0) begin : g_range
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= rem[s];
          dv[s+1]  <= dv[s];
          q[s+1]   <= q[s];
          neg[s+1] <= neg[s];
          big[s+1] <= take;
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= take ? rem[s] - shd : rem[s];
          dv[s+1]  <= dv[s];
          q[s+1]   <= take ? (q[s] | (QB'(1) << J)) : q[s];
          neg[s+1] <= neg[s];
          big[s+1] <= big[s];
        end
      end
    end
  end

  assign sat = big[QB+1] ||
               (q[QB+1] > (neg[QB+1] ? QB'(SAT_NEG) : QB'(SAT_POS)));

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      ovf <= sat;
      if (sat) cen <= neg[QB+1] ? SAT_NEG : SAT_POS;
      else     cen <= neg[QB+1] ? -32'(q[QB+1]) : 32'(q[QB+1]);
    end
  end
endmodule

[src/cfs_rad.sv]
// ----------------------------------------------------------------------------
// cfs_rad: pipelined radius unit
// Squares the center-to-a distance, saturates the sum and takes a rounded
// integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cfs_rad (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] cen [3],
  input  logic signed [31:0] pa  [3],
  output logic [30:0]        rad,
  output logic               ovf
);
  import cfs_pkg::*;

  localparam int NS = SQRT_STEPS;

  logic [32:0]     gap  [3];
  logic [64:0]     sq   [3];
  logic [66:0]     sum;
  logic [SQ_W-1:0] srem [NS+1];
  logic [SQ_W:0]   rr   [NS+1];
  logic            sat  [NS+1];
  logic            rnd;

  assign sum = 67'(sq[0]) + 67'(sq[1]) + 67'(sq[2]);

  // Take distances, squares and the saturated sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        gap[k] <= (cen[k] >= pa[k]) ? 33'(33'(cen[k]) - 33'(pa[k]))
                                    : 33'(33'(pa[k]) - 33'(cen[k]));
        sq[k]  <= 65'(gap[k] * gap[k]);
      end
      srem[0] <= sum[SQ_W-1:0];
      rr[0]   <= '0;
      sat[0]  <= sum > 67'(SLIM);
    end
  end

  // Resolve one root bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_root
    localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (NS - 1 - s));
    logic [SQ_W:0] t;
    logic          take;
    assign t    = rr[s] + BIT;
    assign take = {1'b0, srem[s]} >= t;
    always_ff @(posedge clk) begin
      if (en) begin
        srem[s+1] <= take ? srem[s] - t[SQ_W-1:0] : srem[s];
        rr[s+1]   <= take ? (rr[s] >> 1) + BIT : rr[s] >> 1;
        sat[s+1]  <= sat[s];
      end
    end
  end

  assign rnd = {1'b0, srem[NS]} > rr[NS];

  // Round to nearest and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      ovf <= sat[NS];
      rad <= sat[NS] ? '1 : rr[NS][RAD_W-1:0] + RAD_W'(rnd);
    end
  end
endmodule

[src/circumsphere_from_four_points_unit.sv]
// ----------------------------------------------------------------------------
// circumsphere_from_four_points_unit: sphere through four points
// Input channel pts (valid/ready) carries four Q16.16 points a, b, third, d.
// Output channel sph (valid/ready) carries center, radius and the flags
// coplanar and overflow, one result per input item, in order.
// Throughput: one item per cycle unless the receiver stalls; the chain of
// per-bit divider stages and square-root stages sets the depth, and all
// stages advance together.
// Center: exact 3x3 cofactors and Cramer numerators through pipelined wide
// multipliers, then a pipelined rounding divider per coordinate.
// Radius: distance to point a, square-root unit with one bit per stage.
// Reset clears every valid bit; data registers keep their contents.
// When the receiver stalls, the whole pipeline holds and pts_ready drops;
// nothing is lost or repeated, and a result waits in the output register.
// ----------------------------------------------------------------------------
module circumsphere_from_four_points_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              pts_valid,
  output logic              pts_ready,
  input  cfs_pkg::cfs_in_t  pts,
  output logic              sph_valid,
  input  logic              sph_ready,
  output cfs_pkg::cfs_out_t sph
);
  import cfs_pkg::*;

  localparam int TOT = 7 + DIV_LAT + RAD_LAT;
  localparam logic signed [DET_W-1:0] COP_HI = DET_W'(COPLANAR_LIMIT);
  localparam logic signed [DET_W-1:0] COP_LO = -COP_HI;

  logic            en;
  logic [TOT:1]    vld;

  logic signed [COORD_W-1:0] pc [4][3];
  logic signed [DIFF_W-1:0]  m   [9];
  logic signed [COORD_W-1:0] ap  [3];
  logic signed [COORD_W-1:0] dp  [3];
  logic signed [PROD_W-1:0]  pp  [18];
  logic signed [PROD_W-1:0]  sq  [9];
  logic signed [MD_W-1:0]    md  [9];
  logic signed [DIFF_W-1:0]  mc2 [3];
  logic signed [DIFF_W-1:0]  mc3 [3];
  logic signed [COF_W-1:0]   cof [9];
  logic signed [G_W-1:0]     g   [9];
  logic signed [NUM_W-1:0]   prod [9];
  logic signed [DET_W-1:0]   detp [3];
  logic signed [NUM_W-1:0]   num  [3];
  logic signed [DET_W-1:0]   det;
  logic                      cop_now;
  logic signed [COORD_W-1:0] cdiv [3];
  logic                      odiv [3];
  logic [3*COORD_W-1:0]      a_dl;
  logic signed [COORD_W-1:0] arad [3];
  logic [RAD_W-1:0]          rad;
  logic                      rovf;
  logic [3*COORD_W:0]        c_dl;
  logic                      cop_dl;
  cfs_out_t                  sph_next;

  // Hold every stage while a result waits
  assign en        = !sph_valid || sph_ready;
  assign pts_ready = en;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      sph_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[TOT-1:1], pts_valid};
      sph_valid <= vld[TOT];
    end
  end

  assign pc[0] = '{pts.a_x,  pts.a_y,  pts.a_z};
  assign pc[1] = '{pts.b_x,  pts.b_y,  pts.b_z};
  assign pc[2] = '{pts.p3_x, pts.p3_y, pts.p3_z};
  assign pc[3] = '{pts.d_x,  pts.d_y,  pts.d_z};

  // Subtract d from the other points
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          m[i*3+k] <= DIFF_W'(pc[i][k]) - DIFF_W'(pc[3][k]);
      for (int k = 0; k < 3; k++) begin
        ap[k] <= pc[0][k];
        dp[k] <= pc[3][k];
      end
    end
  end

  // Form minor products, squares and m*d terms
  for (genvar n = 0; n < 18; n++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) pp[n] <= m[PAIR_A[n]] * m[PAIR_B[n]];
    end
  end
  for (genvar c = 0; c < 9; c++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq[c] <= m[c] * m[c];
        md[c] <= m[c] * dp[c % 3];
      end
    end
  end

  // Form cofactors and the modified right-hand side
  for (genvar c = 0; c < 9; c++) begin : g_cof
    localparam int R = c / 3;
    always_ff @(posedge clk) begin
      if (en) begin
        cof[c] <= COF_W'(pp[2*c]) - COF_W'(pp[2*c+1]);
        g[c]   <= G_W'(sq[R*3]) + G_W'(sq[R*3+1]) + G_W'(sq[R*3+2]) +
                  (G_W'(md[c]) <<< 1);
      end
    end
  end

  // Carry the first column along for the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mc2[i] <= m[i*3];
        mc3[i] <= mc2[i];
      end
    end
  end

  for (genvar c = 0; c < 9; c++) begin : g_nmul
    cfs_mul #(.WA(COF_W), .WB(G_W)) u_nmul (
      .clk (clk), .en (en), .a (cof[c]), .b (g[c]), .p (prod[c])
    );
  end
  for (genvar i = 0; i < 3; i++) begin : g_dmul
    cfs_mul #(.WA(COF_W), .WB(DIFF_W)) u_dmul (
      .clk (clk), .en (en), .a (cof[i*3]), .b (mc3[i]), .p (detp[i])
    );
  end

  // Sum Cramer numerators and the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) num[k] <= prod[k] + prod[3+k] + prod[6+k];
      det <= detp[0] + detp[1] + detp[2];
    end
  end

  assign cop_now = (det >= COP_LO) && (det <= COP_HI);

  for (genvar k = 0; k < 3; k++) begin : g_div
    cfs_div #(.WN(NUM_W), .WD(DET_W)) u_div (
      .clk (clk), .en (en), .num (num[k]), .det (det),
      .cen (cdiv[k]), .ovf (odiv[k])
    );
  end

  cfs_delay #(.W(3*COORD_W), .DEPTH(6 + DIV_LAT)) u_a_dl (
    .clk (clk), .en (en), .d ({ap[2], ap[1], ap[0]}), .q (a_dl)
  );
  assign arad = '{a_dl[COORD_W-1:0], a_dl[2*COORD_W-1:COORD_W],
                  a_dl[3*COORD_W-1:2*COORD_W]};

  cfs_rad u_rad (
    .clk (clk), .en (en), .cen (cdiv), .pa (arad), .rad (rad), .ovf (rovf)
  );

  cfs_delay #(.W(3*COORD_W+1), .DEPTH(RAD_LAT)) u_c_dl (
    .clk (clk), .en (en),
    .d   ({cdiv[2], cdiv[1], cdiv[0], odiv[0] | odiv[1] | odiv[2]}),
    .q   (c_dl)
  );

  cfs_delay #(.W(1), .DEPTH(DIV_LAT + RAD_LAT)) u_cop_dl (
    .clk (clk), .en (en), .d (cop_now), .q (cop_dl)
  );

  // Assemble the result; a coplanar item drops everything but its flag
  always_comb begin
    sph_next = '0;
    if (cop_dl) begin
      sph_next.coplanar = 1'b1;
    end else begin
      sph_next.center_x = c_dl[COORD_W:1];
      sph_next.center_y = c_dl[2*COORD_W:COORD_W+1];
      sph_next.center_z = c_dl[3*COORD_W:2*COORD_W+1];
      sph_next.radius   = rad;
      sph_next.overflow = c_dl[0] | rovf;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (en) sph <= sph_next;
  end
endmodule
